[hdl/hpt_pkg.sv]
// Shared package of the homogeneous point transform.
// Holds widths, register codes and the request and pipeline structs; needs nothing else.
package hpt_pkg;

  // Fraction bits of a coordinate.
  localparam int unsigned CoordFrac = 16;
  // Fraction bits of a matrix coefficient.
  localparam int unsigned CoefFrac = 12;
  // Width of a signed coordinate.
  localparam int unsigned CoordW = 32;
  // Width of one coefficient lane.
  localparam int unsigned CoefW = 16;
  // Width of one coordinate by coefficient product.
  localparam int unsigned ProdW = CoordW + CoefW;
  // Accumulator width; sums stay below 2^50 in magnitude.
  localparam int unsigned AccW = 52;
  // Width of an accumulator magnitude.
  localparam int unsigned MagW = AccW - 1;
  // Width of the divider quotient.
  localparam int unsigned QuotW = 32;
  // Numerator bits that feed the quotient steps.
  localparam int unsigned PreShift = QuotW - CoordFrac;
  // Number of quotient steps in the divider.
  localparam int unsigned DivSteps = QuotW;
  // Width of the threshold register.
  localparam int unsigned ThreshW = 17;
  // Width of a matrix row register.
  localparam int unsigned RowW = 64;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegRow0   = 3'd0,
    RegRow1   = 3'd1,
    RegRow2   = 3'd2,
    RegRow3   = 3'd3,
    RegThresh = 3'd4
  } cfg_reg_e;

  // Input request.
  typedef struct packed {
    logic [CoordW-1:0] in_x;
    logic [CoordW-1:0] in_y;
    logic [CoordW-1:0] in_z;
  } hpt_in_t;

  // Result request.
  typedef struct packed {
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic [CoordW-1:0] out_z;
    logic              w_small;
  } hpt_out_t;

  // The four matrix rows.
  typedef logic [3:0][RowW-1:0] hpt_mat_t;

  // Accumulators after the multiply-add stages.
  typedef struct packed {
    logic                       valid;
    logic [3:0][AccW-1:0]       acc;
  } hpt_acc_t;

  // One divider lane.
  typedef struct packed {
    logic [MagW-1:0]  rem;
    logic [QuotW-1:0] quot;
    logic [QuotW-1:0] nbits;
  } hpt_lane_t;

  // One item in the divider pipeline.
  typedef struct packed {
    logic                   valid;
    logic                   w_low;
    logic [MagW-1:0]        den;
    logic [2:0]             neg;
    logic [2:0]             ovf;
    logic [2:0][CoordW-1:0] raw;
    logic [2:0]             [$bits(hpt_lane_t)-1:0] lane;
  } hpt_div_t;

endpackage

[hdl/hpt_mac.sv]
// Multiply-add stages: twelve coordinate by coefficient products, then the four row sums.
// Uses hpt_pkg.
module hpt_mac import hpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  hpt_in_t  data_i,
  input  hpt_mat_t rows_i,
  output hpt_acc_t acc_o
);

  logic                     v1_q;
  logic signed [ProdW-1:0]  prod_q [3][4];
  logic signed [ProdW-1:0]  prod_d [3][4];
  logic signed [CoordW-1:0] pt [3];
  hpt_acc_t                 acc_d, acc_q;

  assign pt[0] = $signed(data_i.in_x);
  assign pt[1] = $signed(data_i.in_y);
  assign pt[2] = $signed(data_i.in_z);

  // Products of each coordinate with its row's coefficients.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        prod_d[r][k] = pt[r] * $signed(rows_i[r][CoefW*k +: CoefW]);
      end
    end
  end

  // Row sums plus the translation aligned to the product scale.
  always_comb begin
    logic signed [AccW-1:0] s;
    acc_d.valid = v1_q;
    for (int k = 0; k < 4; k++) begin
      s = AccW'($signed(rows_i[3][CoefW*k +: CoefW])) <<< CoordFrac;
      for (int r = 0; r < 3; r++) begin
        s = s + AccW'(prod_q[r][k]);
      end
      acc_d.acc[k] = s;
    end
  end

  // Valid bit and accumulator registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      acc_q <= '0;
    end else if (adv_i) begin
      v1_q  <= valid_i;
      acc_q <= acc_d;
    end
  end

  // Product registers.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
    end
  end

  assign acc_o = acc_q;

endmodule

[hdl/hpt_prep.sv]
// Divider setup stage: magnitudes, signs, small-w test, overflow test and undivided results.
// Uses hpt_pkg.
module hpt_prep import hpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  hpt_acc_t           acc_i,
  input  logic [ThreshW-1:0] thresh_i,
  output hpt_div_t           div_o
);

  hpt_div_t div_d, div_q;

  // Shift right by the coefficient fraction, rounding down, then clamp to 32 bits.
  function automatic logic [CoordW-1:0] sat_raw(logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] sh;
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    sh = a >>> CoefFrac;
    hi = $signed({{(AccW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}});
    lo = $signed({{(AccW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}});
    if (sh > hi) begin
      sat_raw = hi[CoordW-1:0];
    end else if (sh < lo) begin
      sat_raw = lo[CoordW-1:0];
    end else begin
      sat_raw = sh[CoordW-1:0];
    end
  endfunction

  always_comb begin
    logic signed [AccW-1:0] w;
    logic signed [AccW-1:0] a;
    logic [AccW-1:0]        wabs;
    logic [AccW-1:0]        nabs;
    logic [MagW-1:0]        nmag;
    hpt_lane_t              ln;
    w    = $signed(acc_i.acc[3]);
    wabs = w[AccW-1] ? AccW'(-w) : AccW'(w);
    div_d.valid = acc_i.valid;
    div_d.den   = wabs[MagW-1:0];
    div_d.w_low = (wabs < AccW'({thresh_i, {CoefFrac{1'b0}}})) || (wabs == '0);
    for (int k = 0; k < 3; k++) begin
      a    = $signed(acc_i.acc[k]);
      nabs = a[AccW-1] ? AccW'(-a) : AccW'(a);
      nmag = nabs[MagW-1:0];
      div_d.neg[k] = a[AccW-1] ^ w[AccW-1];
      // The quotient cannot fit 32 bits once the numerator magnitude reaches w times 2^16.
      div_d.ovf[k] = {{PreShift{1'b0}}, nmag} >= {wabs[MagW-1:0], {PreShift{1'b0}}};
      div_d.raw[k] = sat_raw(a);
      ln.rem   = nmag >> PreShift;
      ln.quot  = '0;
      ln.nbits = {nmag[PreShift-1:0], {CoordFrac{1'b0}}};
      div_d.lane[k] = ln;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
    end else if (adv_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

[hdl/hpt_div_step.sv]
// One registered restoring-division step: one quotient bit for each of the three lanes.
// Uses hpt_pkg.
module hpt_div_step import hpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  hpt_div_t div_i,
  output hpt_div_t div_o
);

  hpt_div_t div_d, div_q;

  // Shift in the next numerator bit and subtract w where it fits.
  always_comb begin
    hpt_lane_t       li;
    hpt_lane_t       lo;
    logic [MagW:0]   t;
    div_d = div_i;
    for (int k = 0; k < 3; k++) begin
      li = div_i.lane[k];
      t  = {li.rem, li.nbits[QuotW-1]};
      if (t >= {1'b0, div_i.den}) begin
        lo.rem  = MagW'(t - {1'b0, div_i.den});
        lo.quot = {li.quot[QuotW-2:0], 1'b1};
      end else begin
        lo.rem  = t[MagW-1:0];
        lo.quot = {li.quot[QuotW-2:0], 1'b0};
      end
      lo.nbits = {li.nbits[QuotW-2:0], 1'b0};
      div_d.lane[k] = lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
    end else if (adv_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

[hdl/homogeneous_point_transform.sv]
// Top level of the homogeneous point transform with perspective divide.
// Uses hpt_pkg, hpt_mac, hpt_prep and hpt_div_step.

// One point request enters per cycle while the output is not stalled; its result passes through
// two multiply-add stages, one divider setup stage, 32 one-bit division stages and the output
// register. The divider resolves one quotient bit per stage for x, y and z at
// once. The whole pipeline holds while a finished result is stalled at the output; no request
// is lost or repeated. Configuration registers accept a write in every cycle and must only be
// written while no request is in flight.
module homogeneous_point_transform import hpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hpt_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hpt_out_t          out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [RowW-1:0]   cfg_data_i
);

  hpt_mat_t           rows_q;
  logic [ThreshW-1:0] thresh_q;
  logic               adv;
  hpt_acc_t           acc;
  hpt_div_t           pipe [DivSteps+1];
  logic               out_valid_q;
  hpt_out_t           out_data_q, out_data_d;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; reset gives the identity matrix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[0] <= RowW'(64'h0000_0000_0000_1000);
      rows_q[1] <= RowW'(64'h0000_0000_1000_0000);
      rows_q[2] <= RowW'(64'h0000_1000_0000_0000);
      rows_q[3] <= RowW'(64'h1000_0000_0000_0000);
      thresh_q  <= ThreshW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegRow0:   rows_q[0] <= cfg_data_i;
        RegRow1:   rows_q[1] <= cfg_data_i;
        RegRow2:   rows_q[2] <= cfg_data_i;
        RegRow3:   rows_q[3] <= cfg_data_i;
        RegThresh: thresh_q  <= cfg_data_i[ThreshW-1:0];
        default:   ;
      endcase
    end
  end

  // The pipeline moves unless a finished result is held at the output.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  hpt_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .rows_i  (rows_q),
    .acc_o   (acc)
  );

  hpt_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .acc_i    (acc),
    .thresh_i (thresh_q),
    .div_o    (pipe[0])
  );

  // Division stages, one quotient bit each.
  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    hpt_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .div_i  (pipe[s]),
      .div_o  (pipe[s+1])
    );
  end

  // Sign and saturation of the quotients, or the undivided values when w is small.
  always_comb begin
    hpt_div_t         f;
    hpt_lane_t        ln;
    logic [CoordW-1:0] r [3];
    f = pipe[DivSteps];
    for (int k = 0; k < 3; k++) begin
      ln = f.lane[k];
      if (f.w_low) begin
        r[k] = f.raw[k];
      end else if (f.neg[k]) begin
        if (f.ovf[k] || (ln.quot > {1'b1, {(QuotW-1){1'b0}}})) begin
          r[k] = {1'b1, {(CoordW-1){1'b0}}};
        end else begin
          r[k] = CoordW'(-ln.quot);
        end
      end else begin
        if (f.ovf[k] || ln.quot[QuotW-1]) begin
          r[k] = {1'b0, {(CoordW-1){1'b1}}};
        end else begin
          r[k] = ln.quot[CoordW-1:0];
        end
      end
    end
    out_data_d.out_x   = r[0];
    out_data_d.out_y   = r[1];
    out_data_d.out_z   = r[2];
    out_data_d.w_small = f.w_low;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pipe[DivSteps].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
